// File: src/separable_box_mean_filter_rgb_defines.svh
// ----------------------------------------------------------------------------
// assertion macros for the separable box mean filter
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SEPARABLE_BOX_MEAN_FILTER_RGB_DEFINES_SVH
`define SEPARABLE_BOX_MEAN_FILTER_RGB_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SBM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbm assertion failed");
// next-cycle implication
`define SBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbm assertion failed");
`else
`define SBM_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/sbm_pkg.sv
// ----------------------------------------------------------------------------
// sbm_pkg
// shared types, constants and helpers of the box mean filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sbm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_MASK   = 15;

    localparam int DIM_W     = 11;                    // config width/height registers
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int MASK_W    = 4;
    localparam int SIDE_W    = MASK_W - 1;
    localparam int RING_ROWS = 2 * (MAX_MASK / 2) + 2;
    localparam int RING_BITS = $clog2(RING_ROWS);
    localparam int WIN_DEPTH = MAX_MASK + 1;
    localparam int WIN_BITS  = $clog2(WIN_DEPTH);
    localparam int SUM_W     = 12;                    // up to 15 * 255
    localparam int RECIP_W   = 17;
    localparam int RECIP_SH  = 16;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int PIX_W     = 24;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MASK   = 2'd2;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_DRAIN = 1'b1
    } sbm_kind_t;

    typedef struct packed {
        sbm_kind_t  kind;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } sbm_item_t;

    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [MASK_W-1:0] mask;
        logic [SIDE_W-1:0] side;
        logic              clear;
    } sbm_cfg_t;

    typedef struct packed {
        logic busy;
    } sbm_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HSUM,
        ST_MUL,
        ST_HWR,
        ST_CHECK,
        ST_VSUM,
        ST_VLAST,
        ST_OUT
    } sbm_state_t;

    // ceil(2^16 / m), exact for sums below 2^12
    function automatic logic [RECIP_W-1:0] recip(input logic [MASK_W-1:0] m);
        logic [RECIP_W-1:0] r;
        case (m)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            4'd11:   r = 17'd5958;
            4'd12:   r = 17'd5462;
            4'd13:   r = 17'd5042;
            4'd14:   r = 17'd4682;
            4'd15:   r = 17'd4370;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sat8(input logic [PROD_W-1:0] p);
        logic [PROD_W-RECIP_SH-1:0] q;
        q = p[PROD_W-1:RECIP_SH];
        return (q > 13'd255) ? 8'd255 : q[7:0];
    endfunction

endpackage
`default_nettype wire

// File: src/sbm_front.sv
// ----------------------------------------------------------------------------
// sbm_front
// accepts beats, tags them pixel or drain, holds them in a two-entry queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbm_front import sbm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             q_valid,
    output sbm_item_t        q_item,
    input  wire logic        q_pop
);

    sbm_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;
    sbm_item_t  in_item;

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb begin
        in_item.kind  = s_tuser ? KIND_DRAIN : KIND_PIXEL;
        in_item.red   = s_tdata[7:0];
        in_item.green = s_tdata[15:8];
        in_item.blue  = s_tdata[23:16];
        wr_ptr_next   = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next   = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next    = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// File: src/sbm_back.sv
// ----------------------------------------------------------------------------
// sbm_back
// horizontal pass into a row ring, vertical pass out of it, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sbm_back import sbm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire sbm_cfg_t    cfg,
    input  wire logic        q_valid,
    input  wire sbm_item_t   q_item,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,
    output logic             m_tlast,
    output sbm_stat_t        stat
);

    localparam int AW = RING_BITS + COL_W;

    sbm_state_t state_reg, state_next;
    logic [MASK_W-1:0]  k_reg, k_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [COL_W-1:0]   last_reg, last_next;
    logic [RING_BITS-1:0] hy_reg, hy_next;
    logic               vert_reg, vert_next;
    logic               pend_reg, pend_next;
    logic [SUM_W-1:0]   sum_reg [3];
    logic [SUM_W-1:0]   sum_next [3];
    logic [PROD_W-1:0]  prod_reg [3];
    logic [PROD_W-1:0]  prod_next [3];
    logic [COL_W-1:0]   in_x_reg, in_x_next;
    logic [DIM_W-1:0]   in_y_reg, in_y_next;
    logic [COL_W-1:0]   out_c_reg, out_c_next;
    logic [ROW_W-1:0]   out_r_reg, out_r_next;
    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    logic [PIX_W-1:0]   win_mem [WIN_DEPTH];
    logic [PIX_W-1:0]   ring_mem [RING_ROWS * MAX_WIDTH];
    logic [PIX_W-1:0]   ring_rdata_reg;
    logic               win_we;
    logic               ring_we;
    logic [AW-1:0]      ring_raddr;
    logic [AW-1:0]      ring_waddr;
    logic [PIX_W-1:0]   ring_wdata;

    logic [MASK_W-1:0]  span;
    logic               row_end;
    logic [11:0]        hb, va;
    logic [DIM_W-1:0]   hx, vy;
    logic [DIM_W-1:0]   nr, nc;
    logic               avail;
    logic [PIX_W-1:0]   win_rd;
    logic [PIX_W-1:0]   add_pix;
    logic               frame_done;

    assign span    = {cfg.side, 1'b0};
    assign row_end = ({1'b0, in_x_reg} == cfg.width - 11'd1);

    // horizontal tap column and vertical tap row, replicated at the frame edges
    always_comb begin
        hb = $signed({2'b00, col_reg}) - $signed({9'd0, cfg.side})
            + $signed({8'd0, k_reg});
        if (hb[11]) begin
            hx = '0;
        end else if (hb >= {1'b0, cfg.width}) begin
            hx = cfg.width - 11'd1;
        end else begin
            hx = hb[DIM_W-1:0];
        end
        va = $signed({2'b00, out_r_reg}) - $signed({9'd0, cfg.side})
            + $signed({8'd0, k_reg});
        if (va[11]) begin
            vy = '0;
        end else if (va >= {1'b0, cfg.height}) begin
            vy = cfg.height - 11'd1;
        end else begin
            vy = va[DIM_W-1:0];
        end
    end

    // last input the pending output depends on
    always_comb begin
        nr = ({1'b0, out_r_reg} + {8'd0, cfg.side} < cfg.height)
            ? {1'b0, out_r_reg} + {8'd0, cfg.side} : cfg.height - 11'd1;
        nc = ({1'b0, out_c_reg} + {8'd0, cfg.side} < cfg.width)
            ? {1'b0, out_c_reg} + {8'd0, cfg.side} : cfg.width - 11'd1;
        avail = (in_y_reg > nr) || ((in_y_reg == nr) && ({1'b0, in_x_reg} > nc));
    end

    assign win_rd     = win_mem[hx[WIN_BITS-1:0]];
    assign ring_raddr = {vy[RING_BITS-1:0], out_c_reg};
    assign ring_waddr = {hy_reg, col_reg};
    assign ring_wdata = {sat8(prod_reg[2]), sat8(prod_reg[1]), sat8(prod_reg[0])};
    assign frame_done = ({1'b0, out_c_reg} == cfg.width - 11'd1)
        && ({1'b0, out_r_reg} == cfg.height - 11'd1);

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        col_next     = col_reg;
        last_next    = last_reg;
        hy_next      = hy_reg;
        vert_next    = vert_reg;
        pend_next    = pend_reg;
        sum_next     = sum_reg;
        prod_next    = prod_reg;
        in_x_next    = in_x_reg;
        in_y_next    = in_y_reg;
        out_c_next   = out_c_reg;
        out_r_next   = out_r_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        q_pop        = 1'b0;
        win_we       = 1'b0;
        ring_we      = 1'b0;
        add_pix      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop    = 1'b1;
                    k_next   = '0;
                    sum_next = '{default: '0};
                    state_next = ST_CHECK;
                    // surplus pixels act as drains
                    if (q_item.kind == KIND_PIXEL && in_y_reg < cfg.height) begin
                        win_we  = 1'b1;
                        hy_next = in_y_reg[RING_BITS-1:0];
                        if (row_end) begin
                            in_x_next  = '0;
                            in_y_next  = in_y_reg + 11'd1;
                            last_next  = cfg.width[COL_W-1:0] - 10'd1;
                            col_next   = (in_x_reg >= {7'd0, cfg.side})
                                ? in_x_reg - {7'd0, cfg.side} : '0;
                            state_next = ST_HSUM;
                        end else begin
                            in_x_next = in_x_reg + 10'd1;
                            if (in_x_reg >= {7'd0, cfg.side}) begin
                                col_next   = in_x_reg - {7'd0, cfg.side};
                                last_next  = in_x_reg - {7'd0, cfg.side};
                                state_next = ST_HSUM;
                            end
                        end
                    end
                end
            end
            ST_HSUM: begin
                add_pix = win_rd;
                for (int ch = 0; ch < 3; ch++) begin
                    sum_next[ch] = sum_reg[ch] + {4'd0, add_pix[8*ch +: 8]};
                end
                k_next = k_reg + 4'd1;
                if (k_reg == span) begin
                    vert_next  = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                for (int ch = 0; ch < 3; ch++) begin
                    prod_next[ch] = sum_reg[ch] * recip(cfg.mask);
                end
                state_next = vert_reg ? ST_OUT : ST_HWR;
            end
            ST_HWR: begin
                ring_we = 1'b1;
                if (col_reg == last_reg) begin
                    state_next = ST_CHECK;
                end else begin
                    col_next   = col_reg + 10'd1;
                    k_next     = '0;
                    sum_next   = '{default: '0};
                    state_next = ST_HSUM;
                end
            end
            ST_CHECK: begin
                k_next     = '0;
                sum_next   = '{default: '0};
                pend_next  = 1'b0;
                state_next = avail ? ST_VSUM : ST_IDLE;
            end
            ST_VSUM: begin
                // the ring read is registered and lands in the cycle after its address
                add_pix = pend_reg ? ring_rdata_reg : '0;
                for (int ch = 0; ch < 3; ch++) begin
                    sum_next[ch] = sum_reg[ch] + {4'd0, add_pix[8*ch +: 8]};
                end
                pend_next = 1'b1;
                k_next    = k_reg + 4'd1;
                if (k_reg == span) begin
                    state_next = ST_VLAST;
                end
            end
            ST_VLAST: begin
                add_pix = ring_rdata_reg;
                for (int ch = 0; ch < 3; ch++) begin
                    sum_next[ch] = sum_reg[ch] + {4'd0, add_pix[8*ch +: 8]};
                end
                vert_next  = 1'b1;
                state_next = ST_MUL;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = ring_wdata;
                    m_last_next  = frame_done;
                    state_next   = ST_IDLE;
                    if (frame_done) begin
                        in_x_next  = '0;
                        in_y_next  = '0;
                        out_c_next = '0;
                        out_r_next = '0;
                    end else if ({1'b0, out_c_reg} == cfg.width - 11'd1) begin
                        out_c_next = '0;
                        out_r_next = out_r_reg + 10'd1;
                    end else begin
                        out_c_next = out_c_reg + 10'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a register write restarts the frame
        if (cfg.clear) begin
            in_x_next  = '0;
            in_y_next  = '0;
            out_c_next = '0;
            out_r_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            out_c_reg   <= '0;
            out_r_reg   <= '0;
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
            vert_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
            out_c_reg   <= out_c_next;
            out_r_reg   <= out_r_next;
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
            vert_reg    <= vert_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        col_reg    <= col_next;
        last_reg   <= last_next;
        hy_reg     <= hy_next;
        sum_reg    <= sum_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[in_x_reg[WIN_BITS-1:0]] <= {q_item.blue, q_item.green, q_item.red};
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tlast   = m_last_reg;
    assign stat.busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

// File: src/separable_box_mean_filter_rgb.sv
// ----------------------------------------------------------------------------
// separable_box_mean_filter_rgb
// box mean filter over an rgb raster stream with replicated borders
// ----------------------------------------------------------------------------
// Pixels enter in raster order; a drain beat (tuser high) carries no pixel and
// only pushes out a pending result. Each beat yields at most one result, the
// next output pixel in raster order once all pixels it needs have arrived.
// Beats are queued two deep and worked one at a time by a single shared
// accumulator: a beat completes at most one horizontal column (up to m/2+1
// at a row end) into the row ring and may release a result, m being the
// mask size. The accumulator walks the taps one per cycle through the window
// registers and the single read port of the row ring. Any register write
// restarts the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "separable_box_mean_filter_rgb_defines.svh"
module separable_box_mean_filter_rgb import sbm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // red, green, blue
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_red, out_green, out_blue
    output logic             m_tlast
);

    logic [DIM_W-1:0]  w_reg, w_next;
    logic [DIM_W-1:0]  h_reg, h_next;
    logic [MASK_W-1:0] m_reg, m_next;
    sbm_cfg_t          cfg;
    sbm_stat_t         back_stat;
    logic              q_valid;
    sbm_item_t         q_item;
    logic              q_pop;

    always_comb begin
        w_next = w_reg;
        h_next = h_reg;
        m_next = m_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WIDTH: begin
                    w_next = (cfg_wdata == 11'd0) ? 11'd1
                        : (cfg_wdata > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : cfg_wdata;
                end
                CFG_HEIGHT: begin
                    h_next = (cfg_wdata == 11'd0) ? 11'd1
                        : (cfg_wdata > 11'(MAX_HEIGHT)) ? 11'(MAX_HEIGHT) : cfg_wdata;
                end
                CFG_MASK: begin
                    m_next = (cfg_wdata[3:0] == 4'd0) ? 4'd1 : cfg_wdata[3:0];
                end
                default: begin
                end
            endcase
        end
        cfg.width  = w_reg;
        cfg.height = h_reg;
        cfg.mask   = m_reg;
        cfg.side   = m_reg[MASK_W-1:1];
        cfg.clear  = cfg_wr_en && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)
            || (cfg_index == CFG_MASK));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_reg <= 11'(MAX_WIDTH);
            h_reg <= 11'(MAX_HEIGHT);
            m_reg <= 4'd3;
        end else begin
            w_reg <= w_next;
            h_reg <= h_next;
            m_reg <= m_next;
        end
    end

    sbm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    sbm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .stat     (back_stat)
    );

    `SBM_ASSERT_NOW(a_dims_legal, aclk, aresetn, 1'b1, (w_reg != 11'd0) && (h_reg != 11'd0) && (m_reg != 4'd0))
    `SBM_ASSERT_NOW(a_result_from_work, aclk, aresetn, $rose(m_tvalid), $past(back_stat.busy))
    `SBM_ASSERT_NEXT(a_mask_write, aclk, aresetn, cfg_wr_en && (cfg_index == CFG_MASK), m_reg == $past(m_next))

endmodule
`default_nettype wire

// File: tb/sbm_checker.sv
// ----------------------------------------------------------------------------
// sbm_checker
// watches both streams of the box mean filter, predicts every output pixel
// from the accepted input beats and register writes, and compares in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module sbm_checker import sbm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [23:0] s_tdata,   // red, green, blue
    input  wire logic        s_tuser,   // mode
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // out_red, out_green, out_blue
    input  wire logic        m_tlast,
    output int               errors,
    output int               pending,
    output logic             frame_open
);

    typedef struct packed {
        logic [23:0] rgb;
        logic        last;
    } out_pixel_t;

    out_pixel_t  owed_pixels[$];

    logic [23:0] line_win [WIN_DEPTH];
    logic [23:0] hrow_ring [RING_ROWS][MAX_WIDTH];
    int unsigned in_count, out_count;
    int unsigned reg_w, reg_h, reg_m;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic logic [7:0] div_sat(input int unsigned sum, input int unsigned m);
        int unsigned q;
        q = sum / m;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    task automatic horiz_column(input int unsigned y, input int unsigned c,
                                input int unsigned w, input int unsigned m);
        int unsigned side, x, ch;
        int b;
        int unsigned acc[3];
        logic [23:0] res;
        side = m / 2;
        acc = '{0, 0, 0};
        for (b = int'(c) - int'(side); b <= int'(c) + int'(side); b++) begin
            if (b < 0) x = 0;
            else if (b >= int'(w)) x = w - 1;
            else x = b;
            for (ch = 0; ch < 3; ch++) acc[ch] += line_win[x % WIN_DEPTH][8*ch +: 8];
        end
        for (ch = 0; ch < 3; ch++) res[8*ch +: 8] = div_sat(acc[ch], m);
        hrow_ring[y % RING_ROWS][c] = res;
    endtask

    task automatic filter_beat(input logic drain, input logic [23:0] px);
        int unsigned w, h, m, side, total, x, y, c, r, nr, nc, cc, ch, yy;
        int a;
        int unsigned acc[3];
        out_pixel_t o;
        w = clamp_dim(reg_w, MAX_WIDTH);
        h = clamp_dim(reg_h, MAX_HEIGHT);
        m = clamp_dim(reg_m, MAX_MASK);
        side = m / 2;
        total = w * h;
        if (!drain && in_count < total) begin
            x = in_count % w;
            y = in_count / w;
            line_win[x % WIN_DEPTH] = px;
            if (x + 1 < w) begin
                if (x >= side) horiz_column(y, x - side, w, m);
            end else begin
                for (cc = (x >= side) ? x - side : 0; cc < w; cc++) horiz_column(y, cc, w, m);
            end
            in_count++;
        end
        r = out_count / w;
        c = out_count % w;
        nr = (r + side < h) ? r + side : h - 1;
        nc = (c + side < w) ? c + side : w - 1;
        if (in_count <= nr * w + nc) return;
        acc = '{0, 0, 0};
        for (a = int'(r) - int'(side); a <= int'(r) + int'(side); a++) begin
            if (a < 0) yy = 0;
            else if (a >= int'(h)) yy = h - 1;
            else yy = a;
            for (ch = 0; ch < 3; ch++) acc[ch] += hrow_ring[yy % RING_ROWS][c][8*ch +: 8];
        end
        for (ch = 0; ch < 3; ch++) o.rgb[8*ch +: 8] = div_sat(acc[ch], m);
        out_count++;
        o.last = (out_count >= total);
        if (o.last) begin
            in_count = 0;
            out_count = 0;
        end
        owed_pixels.push_back(o);
    endtask

    always @(posedge aclk) begin
        out_pixel_t e;
        if (!aresetn) begin
            foreach (line_win[i]) line_win[i] = '0;
            in_count = 0;
            out_count = 0;
            reg_w = MAX_WIDTH;
            reg_h = MAX_HEIGHT;
            reg_m = 3;
            errors <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_pixels.size() == 0) begin
                    $display("%0t: unexpected output beat: expected none, actual rgb %h last %b",
                             $time, m_tdata, m_tlast);
                    errors <= errors + 1;
                end else begin
                    e = owed_pixels.pop_front();
                    if (m_tdata !== e.rgb || m_tlast !== e.last) begin
                        $display("%0t: output mismatch: expected rgb %h last %b, actual rgb %h last %b",
                                 $time, e.rgb, e.last, m_tdata, m_tlast);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WIDTH:  reg_w = cfg_wdata;
                    CFG_HEIGHT: reg_h = cfg_wdata;
                    CFG_MASK:   reg_m = cfg_wdata[3:0];
                    default:    ;
                endcase
                if (cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_MASK}) begin
                    in_count = 0;
                    out_count = 0;
                end
            end
            if (s_tvalid && s_tready) filter_beat(s_tuser, s_tdata);
        end
        pending <= owed_pixels.size();
        frame_open <= (in_count != 0) || (out_count != 0);
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the separable box mean filter: directed corner frames, then
// random frames with random sizes and masks, drains, surplus pixels and aborts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import sbm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 300;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [10:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    int          errors, pending;
    logic        frame_open;
    int          beats_sent = 0;
    int          cycles = 0;
    bit          no_gaps = 0;
    int          hold;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    separable_box_mean_filter_rgb dut (.*);

    sbm_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // output side stall, drawn per result beat
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold = 0;
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) hold = no_gaps ? 0 : $urandom_range(0, 18);
            else if (hold > 0) hold--;
            m_tready <= (hold == 0);
        end
    end

    task automatic send_beat(input logic mode, input logic [23:0] rgb);
        int g;
        g = no_gaps ? 0 : $urandom_range(0, 18);
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= rgb;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] val);
        s_tvalid <= 0;
        // let the owed count catch up with the last accepted beat
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [23:0] pick_rgb(input int flavor);
        case (flavor)
            0:       return 24'h000000;
            1:       return 24'hffffff;
            default: return 24'($urandom());
        endcase
    endfunction

    // full or aborted frame; trailing drains and surplus pixels close it out
    task automatic run_frame(input int w, input int h, input int m, input int npix,
                             input int flavor, input bit close_out);
        int i;
        write_reg(CFG_WIDTH, 11'(w));
        write_reg(CFG_HEIGHT, 11'(h));
        write_reg(CFG_MASK, 11'(m));
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(0, 9) == 0) send_beat(KIND_DRAIN, 24'($urandom()));
            send_beat(KIND_PIXEL, pick_rgb(flavor));
        end
        if (close_out) begin
            s_tvalid <= 0;
            @(posedge aclk);
            while (frame_open) begin
                if ($urandom_range(0, 3) == 0) send_beat(KIND_PIXEL, 24'($urandom()));
                else send_beat(KIND_DRAIN, 24'($urandom()));
            end
        end
    endtask

    initial begin
        int w, h, m, ew, eh, total, flavor;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // single pixel frames at both color extremes
        run_frame(1, 1, 1, 1, 0, 1);
        run_frame(1, 1, 1, 1, 1, 1);
        // out of range registers, then an abort mid frame
        run_frame(0, 2047, 0, 3, 2, 0);
        run_frame(1024, 1024, 15, 2, 2, 0);
        // widest mask on a tiny frame saturates
        run_frame(3, 2, 15, 6, 1, 1);
        run_frame(2, 2, 4, 4, 2, 1);

        while (beats_sent < 1350) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 30) == 0) begin
                w = $urandom_range(100, 220);
                h = 1;
            end else begin
                w = $urandom_range(0, 14);
                h = $urandom_range(0, 8);
            end
            m = $urandom_range(0, 15);
            ew = (w < 1) ? 1 : w;
            eh = (h < 1) ? 1 : h;
            total = ew * eh;
            flavor = ($urandom_range(0, 5) < 2) ? $urandom_range(0, 1) : 2;
            if ($urandom_range(0, 9) == 0)
                run_frame(w, h, m, $urandom_range(0, total - 1), flavor, 0);
            else
                run_frame(w, h, m, total, flavor, 1);
        end

        s_tvalid <= 0;
        no_gaps = 0;
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
